>>> rtl/ltp_pkg.sv
// Shared types, codes and helpers for the log timestamp parser.
package ltp_pkg;

  // Result status codes
  localparam logic [3:0] ST_OK        = 4'd0;
  localparam logic [3:0] ST_END_EARLY = 4'd1;
  localparam logic [3:0] ST_BAD_OPEN  = 4'd2;
  localparam logic [3:0] ST_BAD_DIGIT = 4'd3;
  localparam logic [3:0] ST_HOUR_RNG  = 4'd4;
  localparam logic [3:0] ST_BAD_SEP   = 4'd5;
  localparam logic [3:0] ST_MIN_RNG   = 4'd6;
  localparam logic [3:0] ST_SEC_RNG   = 4'd7;
  localparam logic [3:0] ST_BAD_CLOSE = 4'd8;

  // Parser phases
  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_LEAD  = 4'd1;
  localparam logic [3:0] PH_POPEN = 4'd2;
  localparam logic [3:0] PH_H1    = 4'd3;
  localparam logic [3:0] PH_H2    = 4'd4;
  localparam logic [3:0] PH_SEP1  = 4'd5;
  localparam logic [3:0] PH_M1    = 4'd6;
  localparam logic [3:0] PH_M2    = 4'd7;
  localparam logic [3:0] PH_SEP2  = 4'd8;
  localparam logic [3:0] PH_S1    = 4'd9;
  localparam logic [3:0] PH_S2    = 4'd10;
  localparam logic [3:0] PH_TAIL  = 4'd11;

  // Register indexes on the config port
  localparam logic [2:0] REG_SECONDS_PRESENT = 3'd0;
  localparam logic [2:0] REG_OPEN_PRESENT    = 3'd1;
  localparam logic [2:0] REG_CLOSE_PRESENT   = 3'd2;
  localparam logic [2:0] REG_OPEN_CHAR       = 3'd3;
  localparam logic [2:0] REG_CLOSE_CHAR      = 3'd4;
  localparam logic [2:0] REG_SEPARATOR_CHAR  = 3'd5;

  localparam logic [7:0] BYTE_NUL   = 8'h00;
  localparam logic [7:0] BYTE_SPACE = 8'h20;
  localparam logic [7:0] BYTE_ZERO  = 8'h30;
  localparam logic [7:0] BYTE_NINE  = 8'h39;

  typedef struct packed {
    logic       seconds_present;
    logic       open_present;
    logic       close_present;
    logic [7:0] open_char;
    logic [7:0] close_char;
    logic [7:0] separator_char;
  } cfg_t;

  typedef struct packed {
    logic [7:0]  ch;
    logic        line_start;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } beat_t;

  typedef struct packed {
    logic [3:0]  status;
    logic [4:0]  hours;
    logic [5:0]  minutes;
    logic [5:0]  seconds;
    logic [15:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic        no_space_warning;
  } result_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= BYTE_ZERO) && (c <= BYTE_NINE);
  endfunction

endpackage

>>> rtl/ltp_cfg_regs.sv
// Configuration register bank of the log timestamp parser.
module ltp_cfg_regs (
  input  logic          clk,
  input  logic          rst,
  input  logic          cfg_we,
  input  logic [2:0]    cfg_index,
  input  logic [7:0]    cfg_data,
  output ltp_pkg::cfg_t cfg
);
  import ltp_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.seconds_present <= 1'b1;
      cfg.open_present    <= 1'b1;
      cfg.close_present   <= 1'b1;
      cfg.open_char       <= 8'd91;
      cfg.close_char      <= 8'd93;
      cfg.separator_char  <= 8'd58;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SECONDS_PRESENT: cfg.seconds_present <= cfg_data[0];
        REG_OPEN_PRESENT:    cfg.open_present    <= cfg_data[0];
        REG_CLOSE_PRESENT:   cfg.close_present   <= cfg_data[0];
        REG_OPEN_CHAR:       cfg.open_char       <= cfg_data;
        REG_CLOSE_CHAR:      cfg.close_char      <= cfg_data;
        REG_SEPARATOR_CHAR:  cfg.separator_char  <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/ltp_parser.sv
// Per-line parse state and the single-byte step logic.
module ltp_parser (
  input  logic             clk,
  input  logic             rst,
  input  ltp_pkg::cfg_t    cfg,
  input  ltp_pkg::beat_t   beat,
  input  logic             advance,
  output logic             emit,
  output ltp_pkg::result_t result
);
  import ltp_pkg::*;

  logic [3:0]  phase, phase_next;
  logic [4:0]  hour_acc, hour_next;
  logic [5:0]  minute_acc, minute_next;
  logic [5:0]  second_acc, second_next;
  logic [15:0] year_latch;
  logic [3:0]  month_latch;
  logic [4:0]  day_latch;

  // Values as seen after a line start has been applied
  logic [3:0]  ph;
  logic [4:0]  h;
  logic [5:0]  m;
  logic [5:0]  s;
  logic [15:0] yr;
  logic [3:0]  mo;
  logic [4:0]  dy;
  logic [7:0]  c;
  logic        digit;
  logic [3:0]  d;
  logic [8:0]  hv, mv, sv;
  logic [3:0]  status;
  logic        warn;
  logic        ok;

  assign c     = beat.ch;
  assign ph    = beat.line_start ? PH_LEAD : phase;
  assign h     = beat.line_start ? 5'd0 : hour_acc;
  assign m     = beat.line_start ? 6'd0 : minute_acc;
  assign s     = beat.line_start ? 6'd0 : second_acc;
  assign yr    = beat.line_start ? beat.year : year_latch;
  assign mo    = beat.line_start ? beat.month : month_latch;
  assign dy    = beat.line_start ? beat.day : day_latch;
  assign digit = is_digit(c);
  assign d     = c[3:0];

  // acc * 10 + digit; the acc holds a single digit at this point
  assign hv = {1'b0, h, 3'b000} + {3'b000, h, 1'b0} + {5'd0, d};
  assign mv = {m, 3'b000} + {2'b00, m, 1'b0} + {5'd0, d};
  assign sv = {s, 3'b000} + {2'b00, s, 1'b0} + {5'd0, d};

  always_comb begin
    phase_next  = ph;
    hour_next   = h;
    minute_next = m;
    second_next = s;
    emit        = 1'b0;
    status      = ST_OK;
    warn        = 1'b0;
    case (ph)
      PH_LEAD: begin
        if (c == BYTE_SPACE) begin
          phase_next = PH_LEAD;
        end else if (c == BYTE_NUL) begin
          emit   = 1'b1;
          status = ST_END_EARLY;
        end else if (cfg.open_present) begin
          if (c != cfg.open_char) begin
            emit   = 1'b1;
            status = ST_BAD_OPEN;
          end else begin
            phase_next = PH_POPEN;
          end
        end else if (!digit) begin
          emit   = 1'b1;
          status = ST_BAD_DIGIT;
        end else begin
          hour_next  = {1'b0, d};
          phase_next = PH_H2;
        end
      end
      PH_POPEN, PH_H1: begin
        // spaces may follow the opening mark
        if (ph == PH_POPEN && c == BYTE_SPACE) begin
          phase_next = PH_POPEN;
        end else if (!digit) begin
          emit   = 1'b1;
          status = ST_BAD_DIGIT;
        end else begin
          hour_next  = {1'b0, d};
          phase_next = PH_H2;
        end
      end
      PH_H2: begin
        if (!digit) begin
          emit   = 1'b1;
          status = ST_BAD_DIGIT;
        end else if (hv >= 9'd24) begin
          emit   = 1'b1;
          status = ST_HOUR_RNG;
        end else begin
          hour_next  = hv[4:0];
          phase_next = PH_SEP1;
        end
      end
      PH_SEP1, PH_SEP2: begin
        if (c == BYTE_NUL || c != cfg.separator_char) begin
          emit   = 1'b1;
          status = ST_BAD_SEP;
        end else begin
          phase_next = (ph == PH_SEP1) ? PH_M1 : PH_S1;
        end
      end
      PH_M1: begin
        if (!digit) begin
          emit   = 1'b1;
          status = ST_BAD_DIGIT;
        end else begin
          minute_next = {2'b00, d};
          phase_next  = PH_M2;
        end
      end
      PH_M2: begin
        if (!digit) begin
          emit   = 1'b1;
          status = ST_BAD_DIGIT;
        end else if (mv >= 9'd60) begin
          emit   = 1'b1;
          status = ST_MIN_RNG;
        end else begin
          minute_next = mv[5:0];
          if (cfg.seconds_present) begin
            phase_next = PH_SEP2;
          end else begin
            second_next = 6'd0;
            phase_next  = PH_TAIL;
          end
        end
      end
      PH_S1: begin
        if (!digit) begin
          emit   = 1'b1;
          status = ST_BAD_DIGIT;
        end else begin
          second_next = {2'b00, d};
          phase_next  = PH_S2;
        end
      end
      PH_S2: begin
        if (!digit) begin
          emit   = 1'b1;
          status = ST_BAD_DIGIT;
        end else if (sv >= 9'd60) begin
          emit   = 1'b1;
          status = ST_SEC_RNG;
        end else begin
          second_next = sv[5:0];
          phase_next  = PH_TAIL;
        end
      end
      PH_TAIL: begin
        emit = 1'b1;
        if (cfg.close_present) begin
          if (c == BYTE_NUL || c != cfg.close_char) begin
            status = ST_BAD_CLOSE;
          end
        end else begin
          warn = (c != BYTE_SPACE);
        end
      end
      default: begin
        phase_next = PH_IDLE;
      end
    endcase
    if (emit) begin
      phase_next = PH_IDLE;
    end
  end

  // Result fields come from the state before this byte's update
  assign ok = (status == ST_OK);
  assign result.status           = status;
  assign result.hours            = ok ? h : 5'd0;
  assign result.minutes          = ok ? m : 6'd0;
  assign result.seconds          = (ok && cfg.seconds_present) ? s : 6'd0;
  assign result.year             = yr;
  assign result.month            = mo;
  assign result.day              = dy;
  assign result.no_space_warning = ok && warn;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_IDLE;
      hour_acc    <= 5'd0;
      minute_acc  <= 6'd0;
      second_acc  <= 6'd0;
      year_latch  <= 16'd0;
      month_latch <= 4'd0;
      day_latch   <= 5'd0;
    end else if (advance) begin
      phase       <= phase_next;
      hour_acc    <= hour_next;
      minute_acc  <= minute_next;
      second_acc  <= second_next;
      year_latch  <= yr;
      month_latch <= mo;
      day_latch   <= dy;
    end
  end

endmodule

>>> rtl/log_timestamp_parser_core.sv
// Top level of the log timestamp parser: input register, parser, result register.
//
// Input channel (in_valid/in_ready) carries one byte of a log line per beat,
// with line_start marking the first byte of a line and the date to pass through.
// A zero byte ends a line. Output channel (out_valid/out_ready) carries one
// result per line: the first error found, or the parsed time on the byte after
// the timestamp. Later bytes of a line produce nothing.
// A byte that ends the parse shows its result once its beat is accepted and
// has passed from the input register through the parse step into the
// result register.
// Throughput: one byte per cycle unless a stalled receiver holds a result;
// the parse step is a small state update and a digit multiply-by-ten between
// the input and result registers. A stalled receiver only holds back a byte
// that produces a result while the result register is still full; bytes that
// produce nothing keep flowing. The config port (cfg_we/cfg_index/cfg_data)
// writes a register; write it only while no line is in flight.
// Reset clears both registers' valid flags, the parse state and the date latch,
// and loads the config defaults: seconds, open and close marks present,
// marks 0x5B and 0x5D, separator 0x3A.
module log_timestamp_parser_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        line_start,
  input  logic [15:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [3:0]  status,
  output logic [4:0]  hours,
  output logic [5:0]  minutes,
  output logic [5:0]  seconds,
  output logic [15:0] year_out,
  output logic [3:0]  month_out,
  output logic [4:0]  day_out,
  output logic        no_space_warning,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ltp_pkg::*;

  cfg_t    cfg;
  beat_t   beat;
  logic    beat_valid;
  logic    advance;
  logic    emit;
  result_t step_result;
  result_t res;

  ltp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  ltp_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .beat    (beat),
    .advance (advance),
    .emit    (emit),
    .result  (step_result)
  );

  // a held byte waits only if it would overwrite an untaken result
  assign advance  = beat_valid && (!emit || !out_valid || out_ready);
  assign in_ready = !beat_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      beat_valid <= 1'b0;
    end else if (in_ready) begin
      beat_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      beat.ch         <= ch;
      beat.line_start <= line_start;
      beat.year       <= year_in;
      beat.month      <= month_in;
      beat.day        <= day_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance && emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && emit) begin
      res <= step_result;
    end
  end

  assign status           = res.status;
  assign hours            = res.hours;
  assign minutes          = res.minutes;
  assign seconds          = res.seconds;
  assign year_out         = res.year;
  assign month_out        = res.month;
  assign day_out          = res.day;
  assign no_space_warning = res.no_space_warning;

  // an error result never carries a time or a warning
  a_err_fields_zero: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status != ST_OK) |->
      (hours == 5'd0 && minutes == 6'd0 && seconds == 6'd0 && !no_space_warning))
    else $error("error result carries time fields");

  // a pending result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (beat_valid && emit && out_valid && !out_ready) |-> !advance)
    else $error("result register overwritten");

  // a byte that ends a parse shows up on the output next cycle
  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (advance && emit) |=> out_valid)
    else $error("result lost");

  // an accepted beat lands in the input register
  a_beat_held: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> beat_valid)
    else $error("accepted beat dropped");

endmodule

>>> tb/ltp_timestamp_checker.sv
// Checker for the log timestamp parser: predicts each line's result and compares.
module ltp_timestamp_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic [7:0]  ch,
  input  logic        line_start,
  input  logic [15:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [3:0]  status,
  input  logic [4:0]  hours,
  input  logic [5:0]  minutes,
  input  logic [5:0]  seconds,
  input  logic [15:0] year_out,
  input  logic [3:0]  month_out,
  input  logic [4:0]  day_out,
  input  logic        no_space_warning,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data,
  output int          mismatch_count,
  output int          stamps_due
);
  import ltp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  cfg_t        cfg_now;
  logic [3:0]  stamp_phase;
  logic [4:0]  hour_acc;
  logic [5:0]  minute_acc;
  logic [5:0]  second_acc;
  logic [15:0] year_latch;
  logic [3:0]  month_latch;
  logic [4:0]  day_latch;
  result_t     stamp_q[$];

  // Advances the parse by one byte; returns 1 when the byte closes out the line.
  function automatic bit parse_step(input beat_t b, output result_t r);
    logic [7:0] c;
    logic [3:0] code;
    bit         done;
    bit         warn;
    bit         digit;
    int         v;
    c = b.ch;
    digit = (c >= BYTE_ZERO) && (c <= BYTE_NINE);
    done = 1'b0;
    warn = 1'b0;
    code = ST_OK;
    r = '0;
    if (b.line_start) begin
      year_latch = b.year;
      month_latch = b.month;
      day_latch = b.day;
      hour_acc = '0;
      minute_acc = '0;
      second_acc = '0;
      stamp_phase = PH_LEAD;
    end
    case (stamp_phase)
      PH_LEAD: begin
        if (c == BYTE_NUL) begin
          done = 1'b1;
          code = ST_END_EARLY;
        end else if (c != BYTE_SPACE) begin
          if (cfg_now.open_present) begin
            if (c == cfg_now.open_char) begin
              stamp_phase = PH_POPEN;
            end else begin
              done = 1'b1;
              code = ST_BAD_OPEN;
            end
          end else if (digit) begin
            hour_acc = 5'(c - BYTE_ZERO);
            stamp_phase = PH_H2;
          end else begin
            done = 1'b1;
            code = ST_BAD_DIGIT;
          end
        end
      end
      PH_POPEN, PH_H1: begin
        // spaces may follow the opening mark
        if (!(stamp_phase == PH_POPEN && c == BYTE_SPACE)) begin
          if (digit) begin
            hour_acc = 5'(c - BYTE_ZERO);
            stamp_phase = PH_H2;
          end else begin
            done = 1'b1;
            code = ST_BAD_DIGIT;
          end
        end
      end
      PH_H2: begin
        if (!digit) begin
          done = 1'b1;
          code = ST_BAD_DIGIT;
        end else begin
          v = hour_acc * 10 + (c - BYTE_ZERO);
          if (v >= 24) begin
            done = 1'b1;
            code = ST_HOUR_RNG;
          end else begin
            hour_acc = 5'(v);
            stamp_phase = PH_SEP1;
          end
        end
      end
      PH_SEP1, PH_SEP2: begin
        // a zero byte never matches, even with a zero separator
        if (c == BYTE_NUL || c != cfg_now.separator_char) begin
          done = 1'b1;
          code = ST_BAD_SEP;
        end else begin
          stamp_phase = (stamp_phase == PH_SEP1) ? PH_M1 : PH_S1;
        end
      end
      PH_M1: begin
        if (digit) begin
          minute_acc = 6'(c - BYTE_ZERO);
          stamp_phase = PH_M2;
        end else begin
          done = 1'b1;
          code = ST_BAD_DIGIT;
        end
      end
      PH_M2: begin
        if (!digit) begin
          done = 1'b1;
          code = ST_BAD_DIGIT;
        end else begin
          v = minute_acc * 10 + (c - BYTE_ZERO);
          if (v >= 60) begin
            done = 1'b1;
            code = ST_MIN_RNG;
          end else begin
            minute_acc = 6'(v);
            if (cfg_now.seconds_present) begin
              stamp_phase = PH_SEP2;
            end else begin
              second_acc = '0;
              stamp_phase = PH_TAIL;
            end
          end
        end
      end
      PH_S1: begin
        if (digit) begin
          second_acc = 6'(c - BYTE_ZERO);
          stamp_phase = PH_S2;
        end else begin
          done = 1'b1;
          code = ST_BAD_DIGIT;
        end
      end
      PH_S2: begin
        if (!digit) begin
          done = 1'b1;
          code = ST_BAD_DIGIT;
        end else begin
          v = second_acc * 10 + (c - BYTE_ZERO);
          if (v >= 60) begin
            done = 1'b1;
            code = ST_SEC_RNG;
          end else begin
            second_acc = 6'(v);
            stamp_phase = PH_TAIL;
          end
        end
      end
      PH_TAIL: begin
        done = 1'b1;
        if (cfg_now.close_present) begin
          if (c == BYTE_NUL || c != cfg_now.close_char) code = ST_BAD_CLOSE;
        end else begin
          warn = (c != BYTE_SPACE);
        end
      end
      default: begin
        stamp_phase = PH_IDLE;
      end
    endcase
    if (done) begin
      r.status = code;
      if (code == ST_OK) begin
        r.hours = hour_acc;
        r.minutes = minute_acc;
        if (cfg_now.seconds_present) r.seconds = second_acc;
        r.no_space_warning = warn;
      end
      r.year = year_latch;
      r.month = month_latch;
      r.day = day_latch;
      stamp_phase = PH_IDLE;
    end
    return done;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin
    beat_t   b;
    result_t r;
    result_t want;
    result_t got;
    if (rst) begin
      cfg_now = '{1'b1, 1'b1, 1'b1, 8'h5B, 8'h5D, 8'h3A};
      stamp_phase = PH_IDLE;
      hour_acc = '0;
      minute_acc = '0;
      second_acc = '0;
      year_latch = '0;
      month_latch = '0;
      day_latch = '0;
      stamp_q.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SECONDS_PRESENT: cfg_now.seconds_present = cfg_data[0];
          REG_OPEN_PRESENT:    cfg_now.open_present = cfg_data[0];
          REG_CLOSE_PRESENT:   cfg_now.close_present = cfg_data[0];
          REG_OPEN_CHAR:       cfg_now.open_char = cfg_data;
          REG_CLOSE_CHAR:      cfg_now.close_char = cfg_data;
          REG_SEPARATOR_CHAR:  cfg_now.separator_char = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        b = '{ch, line_start, year_in, month_in, day_in};
        if (parse_step(b, r)) stamp_q = {stamp_q, r};
      end
      if (out_valid && out_ready) begin
        got = '{status, hours, minutes, seconds, year_out, month_out, day_out,
                no_space_warning};
        if (stamp_q.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got status %0d",
                   $time, got.status);
          mismatch_count++;
        end else begin
          want = stamp_q.pop_front();
          check_field("status", want.status, got.status);
          check_field("hours", want.hours, got.hours);
          check_field("minutes", want.minutes, got.minutes);
          check_field("seconds", want.seconds, got.seconds);
          check_field("year", want.year, got.year);
          check_field("month", want.month, got.month);
          check_field("day", want.day, got.day);
          check_field("no_space_warning", want.no_space_warning, got.no_space_warning);
        end
      end
    end
    stamps_due = stamp_q.size();
  end

endmodule

>>> tb/tb_log_timestamp_parser_core.sv
// Testbench top for the log timestamp parser: clock, reset, stimulus and verdict.
module tb_log_timestamp_parser_core;
  import ltp_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  ch;
  logic        line_start;
  logic [15:0] year_in;
  logic [3:0]  month_in;
  logic [4:0]  day_in;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [3:0]  status;
  logic [4:0]  hours;
  logic [5:0]  minutes;
  logic [5:0]  seconds;
  logic [15:0] year_out;
  logic [3:0]  month_out;
  logic [4:0]  day_out;
  logic        no_space_warning;
  logic        cfg_we;
  logic [2:0]  cfg_index;
  logic [7:0]  cfg_data;

  int mismatch_count;
  int stamps_due;
  int burst_left = 0;
  int random_sent;
  int stall_mode = 0;
  int stall_left = 0;
  int stall_tick = 0;

  log_timestamp_parser_core dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .ch(ch), .line_start(line_start),
    .year_in(year_in), .month_in(month_in), .day_in(day_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .hours(hours), .minutes(minutes), .seconds(seconds),
    .year_out(year_out), .month_out(month_out), .day_out(day_out),
    .no_space_warning(no_space_warning),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ltp_timestamp_checker checker_i (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .ch(ch), .line_start(line_start),
    .year_in(year_in), .month_in(month_in), .day_in(day_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .hours(hours), .minutes(minutes), .seconds(seconds),
    .year_out(year_out), .month_out(month_out), .day_out(day_out),
    .no_space_warning(no_space_warning),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .stamps_due(stamps_due)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver: switches between always-ready, random, periodic and long stalls.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (stall_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        stall_left = $urandom_range(20, 200);
      end
      stall_left--;
      stall_tick++;
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= (stall_tick % 5 >= 2);
        default: out_ready <= (stall_tick % 8 == 0);
      endcase
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

  // One byte beat; bursts of back-to-back beats separated by random gaps.
  task automatic push_byte(input logic [7:0] c, input logic start, input logic [24:0] date);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    ch <= c;
    line_start <= start;
    {year_in, month_in, day_in} <= date;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic push_text(input string s, input logic [24:0] date);
    for (int i = 0; i < s.len(); i++) push_byte(s[i], i == 0, date);
  endtask

  task automatic push_pair(ref logic [7:0] q[$], input int v);
    q = {q, 8'(BYTE_ZERO + v / 10), 8'(BYTE_ZERO + v % 10)};
  endtask

  // Mostly well-formed stamp for the current settings, sometimes damaged.
  task automatic random_line(input cfg_t s);
    logic [7:0]  q[$];
    logic [24:0] date;
    int          cut;
    date = 25'($urandom);
    repeat ($urandom_range(0, 2)) q = {q, BYTE_SPACE};
    if (s.open_present) begin
      q = {q, s.open_char};
      repeat ($urandom_range(0, 2)) q = {q, BYTE_SPACE};
    end
    push_pair(q, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 23));
    q = {q, s.separator_char};
    push_pair(q, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59));
    if (s.seconds_present) begin
      q = {q, s.separator_char};
      push_pair(q, ($urandom_range(0, 7) == 0) ? $urandom_range(0, 99) : $urandom_range(0, 59));
    end
    if (s.close_present && $urandom_range(0, 3) != 0) begin
      q = {q, s.close_char};
    end else begin
      case ($urandom_range(0, 2))
        0: q = {q, BYTE_SPACE};
        1: q = {q, 8'($urandom)};
        default: q = {q, BYTE_NUL};
      endcase
    end
    if ($urandom_range(0, 3) == 0) begin
      cut = $urandom_range(0, q.size() - 1);
      case ($urandom_range(0, 2))
        0: q[cut] = 8'($urandom);
        // left unfinished: the next line start abandons it
        1: while (q.size() > cut + 1) void'(q.pop_back());
        default: begin
          while (q.size() > cut) void'(q.pop_back());
          q = {q, BYTE_NUL};
        end
      endcase
    end
    repeat ($urandom_range(0, 2)) q = {q, 8'($urandom)};
    if ($urandom_range(0, 1) == 0) q = {q, BYTE_NUL};
    foreach (q[i]) push_byte(q[i], i == 0, (i == 0) ? date : 25'($urandom));
    random_sent += q.size();
  endtask

  // Ends any open line, then lets the block drain before settings change.
  task automatic settle();
    push_byte(BYTE_NUL, 1'b0, 25'($urandom));
    in_valid <= 1'b0;
    burst_left = 0;
    do @(negedge clk); while (stamps_due != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input logic [2:0] idx, input logic [7:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic apply_settings(input cfg_t s);
    put_reg(REG_SECONDS_PRESENT, {7'd0, s.seconds_present});
    put_reg(REG_OPEN_PRESENT, {7'd0, s.open_present});
    put_reg(REG_CLOSE_PRESENT, {7'd0, s.close_present});
    put_reg(REG_OPEN_CHAR, s.open_char);
    put_reg(REG_CLOSE_CHAR, s.close_char);
    put_reg(REG_SEPARATOR_CHAR, s.separator_char);
    cfg_we <= 1'b0;
  endtask

  initial begin
    cfg_t plan[9];
    plan[0] = '{1'b1, 1'b1, 1'b1, 8'h5B, 8'h5D, 8'h3A};
    plan[1] = '{1'b0, 1'b0, 1'b0, 8'h5B, 8'h5D, 8'h3A};
    plan[2] = '{1'b1, 1'b0, 1'b1, 8'h00, 8'h00, 8'h2E};
    plan[3] = '{1'b0, 1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF};
    plan[4] = '{1'b1, 1'b1, 1'b1, 8'h20, 8'h20, 8'h3A};
    plan[5] = '{1'b1, 1'b0, 1'b1, 8'h3C, 8'h20, 8'h2D};
    plan[6] = '{1'b0, 1'b0, 1'b1, 8'h00, 8'h3E, 8'h00};
    plan[7] = cfg_t'(27'($urandom));
    plan[8] = cfg_t'(27'($urandom));

    rst <= 1'b1;
    in_valid <= 1'b0;
    ch <= '0;
    line_start <= 1'b0;
    year_in <= '0;
    month_in <= '0;
    day_in <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // bytes before any line start are dropped
    push_byte("A", 1'b0, '1);
    push_byte(8'hFF, 1'b0, '0);
    push_byte(BYTE_NUL, 1'b1, '1);
    push_text(" A", '0);
    push_text("[24", {16'h8000, 4'h8, 5'h10});
    // unfinished line, dropped by the next line start
    push_text("[ 1", {16'h0001, 4'h1, 5'h01});
    push_text("[00:0", {16'h7FFF, 4'h7, 5'h0F});
    push_byte(BYTE_NUL, 1'b0, '1);
    push_text("[23:59:59]", {16'hFFFF, 4'hF, 5'h1F});
    settle();

    random_sent = 0;
    foreach (plan[k]) begin
      apply_settings(plan[k]);
      while (random_sent < (k + 1) * 145) random_line(plan[k]);
      settle();
    end

    repeat (10) @(posedge clk);
    @(negedge clk);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> sim.f
rtl/ltp_pkg.sv
rtl/ltp_cfg_regs.sv
rtl/ltp_parser.sv
rtl/log_timestamp_parser_core.sv
tb/ltp_timestamp_checker.sv
tb/tb_log_timestamp_parser_core.sv
